/* hw/rtl/qte_pkg.sv */
// ----------------------------------------------------------------------------
// qte_pkg: shared types and constants for the quaternion to Euler converter
// Widths, CORDIC arctangent table and the structs passed between the
// front end, the square root cells and the CORDIC cells.
// ----------------------------------------------------------------------------
package qte_pkg;

    // default number of CORDIC rotations per angle (range 12..32)
    localparam int CORDIC_STAGES_DEF = 24;

    // product width after the Q30 floor shift, and width of the term sums
    localparam int PW    = 35;
    localparam int SUM_W = 37;

    // square root radicand / root working width, one cell per result bit
    localparam int RAD_W       = 62;
    localparam int SQRT_STAGES = 31;

    // CORDIC working widths: vector components and Q30 angle
    localparam int CW = 40;
    localparam int ZW = 34;

    localparam longint ONE_Q30 = 64'sd1073741824;
    localparam logic signed [ZW-1:0] HALF_PI_Q30 = ZW'(64'sd1686629713);

    // 57.3 * 100 degrees per radian, and output limits
    localparam int SCALE_W = 13;
    localparam logic [SCALE_W-1:0] CENTIDEG_SCALE = SCALE_W'(5730);
    localparam logic [15:0] LIM_ANGLE = 16'd18000;
    localparam logic [15:0] LIM_PITCH = 16'd9000;

    // atan(2^-i) in Q30 radians, truncated
    localparam logic [31:0] ATAN_TAB [32] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
        32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
        32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
        32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF,
        32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
        32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008,
        32'h00000004, 32'h00000002, 32'h00000001, 32'h00000000
    };

    // front end result: radicand for the cosine plus the atan2 operands
    typedef struct packed {
        logic                    vld;
        logic [RAD_W-1:0]        rad;
        logic signed [31:0]      s;
        logic signed [SUM_W-1:0] ry;
        logic signed [SUM_W-1:0] rx;
        logic signed [SUM_W-1:0] yy;
        logic signed [SUM_W-1:0] yx;
    } front_t;

    // operands riding alongside the square root chain
    typedef struct packed {
        logic signed [31:0]      s;
        logic signed [SUM_W-1:0] ry;
        logic signed [SUM_W-1:0] rx;
        logic signed [SUM_W-1:0] yy;
        logic signed [SUM_W-1:0] yx;
    } side_t;

    // digit-by-digit square root state
    typedef struct packed {
        logic [RAD_W-1:0] rem;
        logic [RAD_W-1:0] root;
    } sqrt_t;

    // one CORDIC lane: vector, accumulated angle, zero-vector mark
    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 zero;
    } lane_t;

endpackage

/* hw/rtl/qte_front.sv */
// ----------------------------------------------------------------------------
// qte_front: quaternion product terms
// Input register, Q30 products, rotation term sums with asin clamp, and the
// radicand 1 - s^2 for the pitch cosine. Four pipeline stages.
// ----------------------------------------------------------------------------
module qte_front
    import qte_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_vld,
    input  logic signed [31:0] quat_w,
    input  logic signed [31:0] quat_x,
    input  logic signed [31:0] quat_y,
    input  logic signed [31:0] quat_z,
    output front_t             front
);

    // doubled product 2ab, floor shift
    function automatic logic signed [PW-1:0] dbl(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        logic signed [63:0] p;
        p = a * b;
        return PW'(p >>> 29);
    endfunction

    // plain product ab, floor shift
    function automatic logic signed [PW-1:0] prd(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        logic signed [63:0] p;
        p = a * b;
        return PW'(p >>> 30);
    endfunction

    logic [3:0] vld_reg;

    logic signed [31:0] w_reg, x_reg, y_reg, z_reg;

    logic signed [PW-1:0] d_yz_reg, d_wx_reg, d_xx_reg, d_yy_reg;
    logic signed [PW-1:0] d_wy_reg, d_xz_reg, d_xy_reg, d_wz_reg;
    logic signed [PW-1:0] p_ww_reg, p_xx_reg, p_yy_reg, p_zz_reg;

    logic signed [SUM_W-1:0] ry_reg, rx_reg, yy_reg, yx_reg;
    logic signed [31:0]      s_reg;
    logic signed [SUM_W-1:0] s_raw;
    logic signed [31:0]      s_next;

    logic signed [SUM_W-1:0] ry2_reg, rx2_reg, yy2_reg, yx2_reg;
    logic signed [31:0]      s2_reg;
    logic [RAD_W-1:0]        rad_reg;
    logic signed [31:0]      s_neg;
    logic [30:0]             s_mag;
    logic [RAD_W-1:0]        s_sq;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[2:0], in_vld};
        end
    end

    // asin argument, clamped to plus or minus one
    always_comb
    begin
        s_raw = SUM_W'(d_wy_reg) - SUM_W'(d_xz_reg);
        if (s_raw > SUM_W'(ONE_Q30))
        begin
            s_next = 32'(ONE_Q30);
        end
        else if (s_raw < -SUM_W'(ONE_Q30))
        begin
            s_next = -32'(ONE_Q30);
        end
        else
        begin
            s_next = 32'(s_raw);
        end
    end

    // 1 - s^2 in Q60
    assign s_neg = -s_reg;
    assign s_mag = s_reg[31] ? s_neg[30:0] : s_reg[30:0];
    assign s_sq  = RAD_W'(s_mag) * RAD_W'(s_mag);

    // datapath stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            w_reg <= quat_w;
            x_reg <= quat_x;
            y_reg <= quat_y;
            z_reg <= quat_z;

            d_yz_reg <= dbl(y_reg, z_reg);
            d_wx_reg <= dbl(w_reg, x_reg);
            d_xx_reg <= dbl(x_reg, x_reg);
            d_yy_reg <= dbl(y_reg, y_reg);
            d_wy_reg <= dbl(w_reg, y_reg);
            d_xz_reg <= dbl(x_reg, z_reg);
            d_xy_reg <= dbl(x_reg, y_reg);
            d_wz_reg <= dbl(w_reg, z_reg);
            p_ww_reg <= prd(w_reg, w_reg);
            p_xx_reg <= prd(x_reg, x_reg);
            p_yy_reg <= prd(y_reg, y_reg);
            p_zz_reg <= prd(z_reg, z_reg);

            ry_reg <= SUM_W'(d_yz_reg) + SUM_W'(d_wx_reg);
            rx_reg <= SUM_W'(ONE_Q30) - SUM_W'(d_xx_reg) - SUM_W'(d_yy_reg);
            s_reg  <= s_next;
            yy_reg <= SUM_W'(d_xy_reg) + SUM_W'(d_wz_reg);
            yx_reg <= SUM_W'(p_ww_reg) + SUM_W'(p_xx_reg)
                      - SUM_W'(p_yy_reg) - SUM_W'(p_zz_reg);

            ry2_reg <= ry_reg;
            rx2_reg <= rx_reg;
            s2_reg  <= s_reg;
            yy2_reg <= yy_reg;
            yx2_reg <= yx_reg;
            rad_reg <= (RAD_W'(1) << 60) - s_sq;
        end
    end

    assign front = '{vld: vld_reg[3], rad: rad_reg, s: s2_reg, ry: ry2_reg,
                     rx: rx2_reg, yy: yy2_reg, yx: yx2_reg};

endmodule

/* hw/rtl/qte_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// qte_sqrt_cell: one bit of a digit-by-digit integer square root
// Trial subtract of root + 4^K from the remainder, registered.
// ----------------------------------------------------------------------------
module qte_sqrt_cell
    import qte_pkg::*;
#(
    parameter int K = 0
)
(
    input  logic  clk,
    input  logic  en,
    input  sqrt_t in_s,
    output sqrt_t out_s
);

    localparam logic [RAD_W-1:0] STEP = RAD_W'(1) << (2 * K);

    sqrt_t            out_reg;
    sqrt_t            out_next;
    logic [RAD_W-1:0] trial;

    // trial subtract
    always_comb
    begin
        trial = in_s.root + STEP;
        if (in_s.rem >= trial)
        begin
            out_next.rem  = in_s.rem - trial;
            out_next.root = (in_s.root >> 1) + STEP;
        end
        else
        begin
            out_next.rem  = in_s.rem;
            out_next.root = in_s.root >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= out_next;
        end
    end

    assign out_s = out_reg;

endmodule

/* hw/rtl/qte_cordic_cell.sv */
// ----------------------------------------------------------------------------
// qte_cordic_cell: one vectoring CORDIC rotation
// Rotates toward y = 0 by atan(2^-IDX) and accumulates the angle.
// ----------------------------------------------------------------------------
module qte_cordic_cell
    import qte_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic  clk,
    input  logic  en,
    input  lane_t in_l,
    output lane_t out_l
);

    localparam logic signed [ZW-1:0] ANG = ZW'(ATAN_TAB[IDX]);

    lane_t                out_reg;
    lane_t                out_next;
    logic signed [CW-1:0] x_in, y_in, xs, ys;
    logic signed [ZW-1:0] z_in;

    assign x_in = in_l.x;
    assign y_in = in_l.y;
    assign z_in = in_l.z;
    assign xs   = x_in >>> IDX;
    assign ys   = y_in >>> IDX;

    // rotation direction from the sign of y
    always_comb
    begin
        out_next.zero = in_l.zero;
        if (y_in > 0)
        begin
            out_next.x = x_in + ys;
            out_next.y = y_in - xs;
            out_next.z = z_in + ANG;
        end
        else
        begin
            out_next.x = x_in - ys;
            out_next.y = y_in + xs;
            out_next.z = z_in - ANG;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= out_next;
        end
    end

    assign out_l = out_reg;

endmodule

/* hw/rtl/quaternion_to_euler_angles_unit.sv */
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_unit: Q30 quaternion to roll, pitch, yaw
// Pipeline: 4 product stages, 31 square root cells, one quadrant stage,
// one cell per rotation, 2 scaling stages, then the output register.
// Throughput: one request per cycle while the skid slot is empty; every
// cell chain is fully pipelined.
// Reset clears all valid bits and the output/skid stage; no clearing pass.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles_unit
    import qte_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,  // quat_w, quat_x, quat_y, quat_z
    input  logic [0:0]   s_tuser,  // quat_present
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [47:0]  m_tdata   // roll_centideg, pitch_centideg, yaw_centideg, pad
);

    localparam int NL = 3;

    logic   en;
    logic   skid_vld_reg;
    front_t front;

    // pipeline runs whenever the skid slot is free
    assign en       = !skid_vld_reg;
    assign s_tready = en;

    qte_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .in_vld (s_tvalid & s_tuser[0]),
        .quat_w ($signed(s_tdata[31:0])),
        .quat_x ($signed(s_tdata[63:32])),
        .quat_y ($signed(s_tdata[95:64])),
        .quat_z ($signed(s_tdata[127:96])),
        .front  (front)
    );

    // square root chain for the pitch cosine
    sqrt_t sq_w [SQRT_STAGES+1];
    assign sq_w[0] = '{rem: front.rad, root: '0};

    for (genvar j = 0; j < SQRT_STAGES; j++)
    begin : g_sqrt
        qte_sqrt_cell #(.K(SQRT_STAGES - 1 - j)) u_cell (
            .clk   (clk),
            .en    (en),
            .in_s  (sq_w[j]),
            .out_s (sq_w[j+1])
        );
    end

    // operands delayed alongside the square root
    logic [SQRT_STAGES-1:0] sv_reg;
    side_t                  side_reg [SQRT_STAGES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sv_reg <= '0;
        end
        else if (en)
        begin
            sv_reg <= {sv_reg[SQRT_STAGES-2:0], front.vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= '{s: front.s, ry: front.ry, rx: front.rx,
                             yy: front.yy, yx: front.yx};
            for (int j = 1; j < SQRT_STAGES; j++)
            begin
                side_reg[j] <= side_reg[j-1];
            end
        end
    end

    // quadrant fold into the right half plane
    function automatic lane_t prerot(input logic signed [CW-1:0] yv,
                                     input logic signed [CW-1:0] xv);
        lane_t r;
        r.zero = (xv == '0) && (yv == '0);
        r.x    = xv;
        r.y    = yv;
        r.z    = '0;
        if (xv < 0)
        begin
            if (yv >= 0)
            begin
                r.x = yv;
                r.y = -xv;
                r.z = HALF_PI_Q30;
            end
            else
            begin
                r.x = -yv;
                r.y = xv;
                r.z = -HALF_PI_Q30;
            end
        end
        return r;
    endfunction

    side_t       side_last;
    logic [30:0] cosine;
    lane_t       pr_reg [NL];
    logic [CORDIC_STAGES:0] cv_reg;

    assign side_last = side_reg[SQRT_STAGES-1];
    assign cosine    = sq_w[SQRT_STAGES].root[30:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pr_reg[0] <= prerot(CW'($signed(side_last.ry)), CW'($signed(side_last.rx)));
            pr_reg[1] <= prerot(CW'($signed(side_last.s)), CW'({1'b0, cosine}));
            pr_reg[2] <= prerot(CW'($signed(side_last.yy)), CW'($signed(side_last.yx)));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cv_reg <= '0;
        end
        else if (en)
        begin
            cv_reg <= {cv_reg[CORDIC_STAGES-1:0], sv_reg[SQRT_STAGES-1]};
        end
    end

    // CORDIC cell rows: roll, pitch, yaw
    lane_t lw [NL][CORDIC_STAGES+1];

    for (genvar l = 0; l < NL; l++)
    begin : g_lane
        assign lw[l][0] = pr_reg[l];
        for (genvar k = 0; k < CORDIC_STAGES; k++)
        begin : g_rot
            qte_cordic_cell #(.IDX(k)) u_cell (
                .clk   (clk),
                .en    (en),
                .in_l  (lw[l][k]),
                .out_l (lw[l][k+1])
            );
        end
    end

    // angle to hundredths of a degree: magnitude, scale, clamp, sign
    logic                    s1_vld_reg, s2_vld_reg;
    logic [ZW-2:0]           mag_reg  [NL];
    logic                    neg1_reg [NL];
    logic [15:0]             c_reg    [NL];
    logic                    neg2_reg [NL];
    logic signed [ZW-1:0]    ang      [NL];
    logic signed [ZW-1:0]    ang_abs  [NL];
    logic [ZW+SCALE_W-2:0]   scaled   [NL];
    logic [15:0]             centi    [NL];

    always_comb
    begin
        for (int l = 0; l < NL; l++)
        begin
            ang[l]     = lw[l][CORDIC_STAGES].z;
            ang_abs[l] = ang[l][ZW-1] ? -ang[l] : ang[l];
            scaled[l]  = (ZW + SCALE_W - 1)'(mag_reg[l])
                         * (ZW + SCALE_W - 1)'(CENTIDEG_SCALE);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg <= cv_reg[CORDIC_STAGES];
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < NL; l++)
            begin
                // a zero vector gives angle zero
                mag_reg[l]  <= lw[l][CORDIC_STAGES].zero ? '0 : ang_abs[l][ZW-2:0];
                neg1_reg[l] <= ang[l][ZW-1] && !lw[l][CORDIC_STAGES].zero;
                c_reg[l]    <= scaled[l][ZW+SCALE_W-2:30];
                neg2_reg[l] <= neg1_reg[l];
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < NL; l++)
        begin
            if (l == 1)
            begin
                centi[l] = (c_reg[l] > LIM_PITCH) ? LIM_PITCH : c_reg[l];
            end
            else
            begin
                centi[l] = (c_reg[l] > LIM_ANGLE) ? LIM_ANGLE : c_reg[l];
            end
            if (neg2_reg[l])
            begin
                centi[l] = -centi[l];
            end
        end
    end

    // output register with one skid slot
    logic        inc_vld;
    logic [47:0] inc_data;
    logic        o_vld_reg, o_vld_next;
    logic        skid_vld_next;
    logic [47:0] out_reg, skid_reg;
    logic        load_out, load_skid, from_skid;

    assign inc_vld  = en && s2_vld_reg;
    assign inc_data = {1'b0, centi[2], centi[1][14:0], centi[0]};

    always_comb
    begin
        o_vld_next    = o_vld_reg;
        skid_vld_next = skid_vld_reg;
        load_out      = 1'b0;
        load_skid     = 1'b0;
        from_skid     = 1'b0;
        if (!o_vld_reg || m_tready)
        begin
            if (skid_vld_reg)
            begin
                load_out      = 1'b1;
                from_skid     = 1'b1;
                o_vld_next    = 1'b1;
                skid_vld_next = 1'b0;
            end
            else
            begin
                load_out   = inc_vld;
                o_vld_next = inc_vld;
            end
        end
        else if (inc_vld)
        begin
            load_skid     = 1'b1;
            skid_vld_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_vld_reg    <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else
        begin
            o_vld_reg    <= o_vld_next;
            skid_vld_reg <= skid_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_reg <= from_skid ? skid_reg : inc_data;
        end
        if (load_skid)
        begin
            skid_reg <= inc_data;
        end
    end

    assign m_tvalid = o_vld_reg;
    assign m_tdata  = out_reg;

    // skid slot only holds a result behind a full output register
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_vld_reg |-> o_vld_reg)
        else $error("skid holds a result while output is empty");

    // skid fills only when the output was stalled
    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_vld_reg) |-> $past(m_tvalid && !m_tready))
        else $error("skid filled without output stall");

    // pitch stays within a quarter turn
    a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata[30:16]) <= 15'sd9000
                      && $signed(m_tdata[30:16]) >= -15'sd9000))
        else $error("pitch out of range");

endmodule

/* verif/euler_angle_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// euler_angle_checker: scoreboard for the quaternion to Euler converter
// Watches both stream channels. Each accepted request that carries a
// quaternion is turned into expected roll, pitch and yaw by a bit-exact
// fixed-point model. Each accepted result is checked against the oldest one.
// ----------------------------------------------------------------------------
module euler_angle_checker
    import qte_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [127:0] s_tdata,   // quat_w, quat_x, quat_y, quat_z
    input  logic [0:0]   s_tuser,   // quat_present
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [47:0]  m_tdata,   // roll_centideg, pitch_centideg, yaw_centideg, pad
    output int           mismatch_count,
    output int           pending
);

    // packed MSB first, so roll lands in the low bits as on m_tdata
    typedef struct packed {
        logic signed [15:0] yaw;
        logic signed [14:0] pitch;
        logic signed [15:0] roll;
    } euler_t;

    localparam longint HALF_PI = longint'(HALF_PI_Q30);

    euler_t expected_angles[$];
    euler_t got;
    euler_t want;
    int     n_mismatch = 0;
    int     n_pending  = 0;

    assign mismatch_count = n_mismatch;
    assign pending        = n_pending;

    // 2ab in Q30, floored
    function automatic longint twice_product(input longint a, input longint b);
        return (a * b) >>> 29;
    endfunction

    // ab in Q30, floored
    function automatic longint plain_product(input longint a, input longint b);
        return (a * b) >>> 30;
    endfunction

    // floor of the square root, bit by bit
    function automatic longint unsigned root_floor(input longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // vectoring CORDIC atan2, Q30 radians
    function automatic longint vector_angle(input longint yin, input longint xin);
        longint xv;
        longint yv;
        longint zv;
        longint xs;
        longint ys;
        longint t;
        xv = xin;
        yv = yin;
        zv = 0;
        if (xv == 0 && yv == 0)
            return 0;
        // fold the left half plane into the right one
        if (xv < 0)
        begin
            if (yv >= 0)
            begin
                t  = xv;
                xv = yv;
                yv = -t;
                zv = HALF_PI;
            end
            else
            begin
                t  = xv;
                xv = -yv;
                yv = t;
                zv = -HALF_PI;
            end
        end
        for (int i = 0; i < CORDIC_STAGES && i < 32; i++)
        begin
            xs = xv >>> i;
            ys = yv >>> i;
            if (yv > 0)
            begin
                xv = xv + ys;
                yv = yv - xs;
                zv = zv + longint'(ATAN_TAB[i]);
            end
            else
            begin
                xv = xv - ys;
                yv = yv + xs;
                zv = zv - longint'(ATAN_TAB[i]);
            end
        end
        return zv;
    endfunction

    // radians to hundredths of a degree, toward zero, clamped
    function automatic longint to_centideg(input longint ang, input longint lim);
        longint m;
        longint c;
        m = (ang < 0) ? -ang : ang;
        c = (m * longint'(CENTIDEG_SCALE)) >>> 30;
        if (c > lim)
            c = lim;
        return (ang < 0) ? -c : c;
    endfunction

    function automatic euler_t predict_euler(input logic [31:0] qw, input logic [31:0] qx,
                                             input logic [31:0] qy, input logic [31:0] qz);
        longint          w;
        longint          x;
        longint          y;
        longint          z;
        longint          ry;
        longint          rx;
        longint          s;
        longint          c;
        longint          yy;
        longint          yx;
        longint unsigned s_sq;
        euler_t          e;
        w = longint'($signed(qw));
        x = longint'($signed(qx));
        y = longint'($signed(qy));
        z = longint'($signed(qz));

        ry = twice_product(y, z) + twice_product(w, x);
        rx = ONE_Q30 - twice_product(x, x) - twice_product(y, y);

        // asin argument saturates at plus or minus one
        s = twice_product(w, y) - twice_product(x, z);
        if (s > ONE_Q30)
            s = ONE_Q30;
        if (s < -ONE_Q30)
            s = -ONE_Q30;
        s_sq = longint'((s < 0) ? -s : s);
        s_sq = s_sq * s_sq;
        c    = longint'(root_floor((64'd1 << 60) - s_sq));

        yy = twice_product(x, y) + twice_product(w, z);
        yx = plain_product(w, w) + plain_product(x, x)
           - plain_product(y, y) - plain_product(z, z);

        e.roll  = 16'(to_centideg(vector_angle(ry, rx), 18000));
        e.pitch = 15'(to_centideg(vector_angle(s, c), 9000));
        e.yaw   = 16'(to_centideg(vector_angle(yy, yx), 18000));
        return e;
    endfunction

    task automatic report_mismatch(input string msg);
        n_mismatch++;
        if (n_mismatch <= 40)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // predict on each accepted request, compare on each accepted result
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready && s_tuser[0])
                expected_angles.push_back(predict_euler(s_tdata[31:0], s_tdata[63:32],
                                                        s_tdata[95:64], s_tdata[127:96]));
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[46:0];
                if (expected_angles.size() == 0)
                    report_mismatch($sformatf("result with none expected: roll %0d pitch %0d yaw %0d",
                                              got.roll, got.pitch, got.yaw));
                else
                begin
                    want = expected_angles.pop_front();
                    if (got.roll != want.roll || got.pitch != want.pitch || got.yaw != want.yaw)
                        report_mismatch($sformatf(
                            "roll %0d/%0d pitch %0d/%0d yaw %0d/%0d (got/expected)",
                            got.roll, want.roll, got.pitch, want.pitch, got.yaw, want.yaw));
                end
            end
            n_pending <= expected_angles.size();
        end
    end

endmodule

/* verif/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: quaternion to Euler converter testbench
// Directed corner quaternions, a long receiver hold-off, then random
// attitudes, near-gimbal-lock, raw and small quaternions under several
// sender and receiver idling mixes. The checker module does the comparing.
// ----------------------------------------------------------------------------
module tb;
    import qte_pkg::*;

    localparam int PIPE_LATENCY = 38 + CORDIC_STAGES_DEF;
    localparam int IDLE_LIMIT   = 2000;
    localparam int PHASE_ITEMS  = 325;

    localparam logic [31:0] Q_ONE           = 32'h4000_0000;
    localparam logic [31:0] Q_NEG_ONE       = 32'hC000_0000;
    localparam logic [31:0] Q_HALF          = 32'h2000_0000;
    localparam logic [31:0] Q_SQRT_HALF     = 32'h2D41_3CCD;
    localparam logic [31:0] Q_NEG_SQRT_HALF = 32'hD2BE_C333;
    localparam logic [31:0] Q_MAX           = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN           = 32'h8000_0000;

    logic         clk      = 1'b0;
    logic         rst_n    = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata  = '0;
    logic [0:0]   s_tuser  = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [47:0]  m_tdata;

    int mismatch_count;
    int pending;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_req      = 0;
    int hold_left     = 0;
    int idle_cycles   = 0;

    always #5 clk = ~clk;

    quaternion_to_euler_angles_unit #(
        .CORDIC_STAGES (CORDIC_STAGES_DEF)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    euler_angle_checker #(
        .CORDIC_STAGES (CORDIC_STAGES_DEF)
    ) i_angle_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .mismatch_count (mismatch_count),
        .pending        (pending)
    );

    // receiver: random stalls, or a long hold-off when one is requested
    always @(posedge clk)
    begin
        if (hold_req > 0)
        begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end

    // watchdog: cycles in a row with no request accepted on either side
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog: nothing accepted for %0d cycles", IDLE_LIMIT);
                $display("FAILURE");
                $finish;
            end
        end
    end

    // offer one request, with random idle cycles ahead of it
    task automatic push_request(input bit present, input logic [31:0] w, input logic [31:0] x,
                                input logic [31:0] y, input logic [31:0] z);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {z, y, x, w};
        s_tuser  <= present;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // sender pauses until every expected result is back
    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    function automatic logic [31:0] jitter(input int span);
        return 32'(int'($urandom_range(2 * span)) - span);
    endfunction

    // random direction scaled to about unit length
    task automatic make_attitude(output logic [31:0] w, output logic [31:0] x,
                                 output logic [31:0] y, output logic [31:0] z,
                                 input real gain);
        real c[4];
        real norm;
        norm = 0.0;
        foreach (c[i])
        begin
            c[i] = real'(int'($urandom_range(2000000)) - 1000000);
            norm = norm + c[i] * c[i];
        end
        if (norm < 1.0)
        begin
            c[0] = 1.0;
            norm = 1.0;
        end
        norm = $sqrt(norm);
        w = 32'($rtoi(c[0] / norm * gain * 1073741824.0));
        x = 32'($rtoi(c[1] / norm * gain * 1073741824.0));
        y = 32'($rtoi(c[2] / norm * gain * 1073741824.0));
        z = 32'($rtoi(c[3] / norm * gain * 1073741824.0));
    endtask

    task automatic random_request(output bit counted);
        int          kind;
        bit          present;
        real         gain;
        logic [31:0] w;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        kind    = $urandom_range(99);
        present = 1'b1;
        if (kind < 55)
        begin
            gain = ($urandom_range(9) < 7) ? 1.0 : 0.95 + real'($urandom_range(170)) / 1000.0;
            make_attitude(w, x, y, z, gain);
        end
        else if (kind < 70)
        begin
            // close to pitch of plus or minus 90, often past the asin limit
            w = Q_SQRT_HALF + jitter(1 << 22);
            y = Q_SQRT_HALF + jitter(1 << 22);
            if ($urandom_range(1))
                y = -y;
            x = jitter(1 << 22);
            z = jitter(1 << 22);
            if ($urandom_range(1))
                {w, x, y, z} = {x, w, z, y};
        end
        else if (kind < 85 || kind >= 92)
        begin
            w = $urandom();
            x = $urandom();
            y = $urandom();
            z = $urandom();
            present = (kind < 85);
        end
        else
        begin
            w = jitter(256);
            x = jitter(256);
            y = jitter(256);
            z = jitter(256);
        end
        push_request(present, w, x, y, z);
        counted = present;
    endtask

    task automatic run_phase(input int send_pct, input int stall, input int n_items);
        int done;
        bit hit;
        send_idle_pct = send_pct;
        stall_pct     = stall;
        done          = 0;
        while (done < n_items)
        begin
            random_request(hit);
            if (hit)
                done++;
        end
        wait_results_drained();
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corners
        push_request(1'b1, '0, '0, '0, '0);                    // zero vector for yaw
        push_request(1'b1, Q_ONE, '0, '0, '0);                 // identity
        push_request(1'b1, '0, Q_ONE, '0, '0);                 // roll on negative x axis
        push_request(1'b1, '0, '0, Q_ONE, '0);                 // yaw on negative x axis
        push_request(1'b1, '0, '0, '0, Q_ONE);
        push_request(1'b1, Q_ONE, '0, Q_ONE, '0);              // asin above one
        push_request(1'b1, Q_ONE, '0, Q_NEG_ONE, '0);          // asin below minus one
        push_request(1'b1, '0, Q_HALF, Q_HALF, '0);            // zero vector for roll
        push_request(1'b1, Q_SQRT_HALF, '0, Q_SQRT_HALF, '0);  // gimbal lock up
        push_request(1'b1, Q_SQRT_HALF, '0, Q_NEG_SQRT_HALF, '0);
        push_request(1'b1, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
        push_request(1'b1, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
        push_request(1'b1, Q_MAX, Q_MIN, Q_MAX, Q_MIN);
        push_request(1'b1, Q_MIN, Q_MAX, Q_MIN, Q_MAX);
        push_request(1'b1, '1, '1, '1, '1);
        push_request(1'b0, '1, '1, '1, '1);                    // no quaternion
        push_request(1'b0, '0, '0, '0, '0);
        push_request(1'b1, Q_NEG_ONE, '0, '0, '0);
        push_request(1'b1, '0, Q_NEG_ONE, '0, '0);
        push_request(1'b1, '0, '0, '0, Q_NEG_ONE);
        push_request(1'b1, Q_MAX, '0, '0, Q_MIN);
        wait_results_drained();

        // long receiver hold-off while the sender keeps offering
        hold_req = 400;
        run_phase(0, 0, 150);

        run_phase(0, 0, PHASE_ITEMS);
        run_phase(58, 0, PHASE_ITEMS);
        run_phase(0, 58, PHASE_ITEMS);
        run_phase(20, 20, PHASE_ITEMS);

        repeat (PIPE_LATENCY + 16) @(posedge clk);
        if (pending != 0)
            $display("%0d expected results never arrived", pending);
        if (mismatch_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/qte_pkg.sv
hw/rtl/qte_front.sv
hw/rtl/qte_sqrt_cell.sv
hw/rtl/qte_cordic_cell.sv
hw/rtl/quaternion_to_euler_angles_unit.sv
verif/euler_angle_checker.sv
verif/tb.sv
